/* sv/tssf_pkg.sv */
package tssf_pkg;

  // Fixed field widths.
  localparam int WORD_W      = 16;
  localparam int SCALE_W     = 12;
  localparam int DIVR_W      = 8;
  localparam int PRESS_SHIFT = 12;
  localparam int EVT_W       = 3 * WORD_W;
  localparam int OUT_DATA_W  = 4 * WORD_W;
  localparam int OUT_USER_W  = 5;

  // Converter command words.
  localparam logic [WORD_W-1:0] CMD_X  = 16'h58d3;
  localparam logic [WORD_W-1:0] CMD_Y  = 16'h5893;
  localparam logic [WORD_W-1:0] CMD_Z1 = 16'h58b3;
  localparam logic [WORD_W-1:0] CMD_Z2 = 16'h58c3;

  // Register reset values.
  localparam logic [SCALE_W-1:0] RST_SCALE = 12'd580;
  localparam logic [WORD_W-1:0]  RST_PMIN  = 16'd200;
  localparam logic [WORD_W-1:0]  RST_PMAX  = 16'd4200;
  localparam logic [WORD_W-1:0]  RST_XEXT  = 16'd320;
  localparam logic [WORD_W-1:0]  RST_YEXT  = 16'd240;
  localparam logic [DIVR_W-1:0]  RST_XDIV  = 8'd6;
  localparam logic [DIVR_W-1:0]  RST_YDIV  = 8'd8;

  typedef struct packed {
    logic [SCALE_W-1:0] pressure_scale;
    logic [WORD_W-1:0]  pressure_min;
    logic [WORD_W-1:0]  pressure_max;
    logic [WORD_W-1:0]  x_extent;
    logic [WORD_W-1:0]  y_extent;
    logic [DIVR_W-1:0]  x_divisor;
    logic [DIVR_W-1:0]  y_divisor;
  } cfg_t;

  typedef enum logic [2:0] {
    REG_SCALE = 3'd0,
    REG_PMIN  = 3'd1,
    REG_PMAX  = 3'd2,
    REG_XEXT  = 3'd3,
    REG_YEXT  = 3'd4,
    REG_XDIV  = 3'd5,
    REG_YDIV  = 3'd6
  } reg_idx_t;

  typedef enum logic [1:0] {
    OP_TICK = 2'd0,
    OP_WORD = 2'd1,
    OP_POP  = 2'd2,
    OP_NOP  = 2'd3
  } opcode_t;

  typedef enum logic [4:0] {
    PH_IDLE = 5'b00001,
    PH_X    = 5'b00010,
    PH_Y    = 5'b00100,
    PH_Z1   = 5'b01000,
    PH_Z2   = 5'b10000
  } phase_t;

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_MUL1   = 7'b0000010,
    ST_MUL2   = 7'b0000100,
    ST_DIV    = 7'b0001000,
    ST_FINISH = 7'b0010000,
    ST_READ   = 7'b0100000,
    ST_OUT    = 7'b1000000
  } state_t;

  typedef enum logic [2:0] {
    SEL_NONE = 3'd0,
    SEL_X    = 3'd1,
    SEL_Y    = 3'd2,
    SEL_Z1   = 3'd3,
    SEL_Z2   = 3'd4
  } sample_sel_t;

  typedef enum logic [2:0] {
    RES_HOLD   = 3'd0,
    RES_ZERO   = 3'd1,
    RES_CMD    = 3'd2,
    RES_FINISH = 3'd3,
    RES_POP    = 3'd4
  } res_op_t;

  // Controller to datapath.
  typedef struct packed {
    sample_sel_t        sample_sel;
    logic               mul1;
    logic               mul2;
    logic               div_step;
    logic               finish;
    logic               pop_read;
    res_op_t            res_op;
    logic [WORD_W-1:0]  cmd_word;
  } dp_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic z1_zero;
    logic div_last;
    logic queue_empty;
  } dp_stat_t;

endpackage

/* sv/tssf_cfg.sv */
module tssf_cfg (
  input  logic                clk,
  input  logic                rst,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [4:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output tssf_pkg::cfg_t      cfg
);

  tssf_pkg::reg_idx_t idx;
  logic               wr_en;

  assign idx   = tssf_pkg::reg_idx_t'(paddr[4:2]);
  assign wr_en = psel && penable && pwrite;

  // Register writes; only each register's own width is kept.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pressure_scale <= tssf_pkg::RST_SCALE;
      cfg.pressure_min   <= tssf_pkg::RST_PMIN;
      cfg.pressure_max   <= tssf_pkg::RST_PMAX;
      cfg.x_extent       <= tssf_pkg::RST_XEXT;
      cfg.y_extent       <= tssf_pkg::RST_YEXT;
      cfg.x_divisor      <= tssf_pkg::RST_XDIV;
      cfg.y_divisor      <= tssf_pkg::RST_YDIV;
    end else if (wr_en) begin
      case (idx)
        tssf_pkg::REG_SCALE: cfg.pressure_scale <= pwdata[tssf_pkg::SCALE_W-1:0];
        tssf_pkg::REG_PMIN:  cfg.pressure_min   <= pwdata[tssf_pkg::WORD_W-1:0];
        tssf_pkg::REG_PMAX:  cfg.pressure_max   <= pwdata[tssf_pkg::WORD_W-1:0];
        tssf_pkg::REG_XEXT:  cfg.x_extent       <= pwdata[tssf_pkg::WORD_W-1:0];
        tssf_pkg::REG_YEXT:  cfg.y_extent       <= pwdata[tssf_pkg::WORD_W-1:0];
        tssf_pkg::REG_XDIV:  cfg.x_divisor      <= pwdata[tssf_pkg::DIVR_W-1:0];
        tssf_pkg::REG_YDIV:  cfg.y_divisor      <= pwdata[tssf_pkg::DIVR_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Read mux.
  always_comb begin
    case (idx)
      tssf_pkg::REG_SCALE: prdata = 32'(cfg.pressure_scale);
      tssf_pkg::REG_PMIN:  prdata = 32'(cfg.pressure_min);
      tssf_pkg::REG_PMAX:  prdata = 32'(cfg.pressure_max);
      tssf_pkg::REG_XEXT:  prdata = 32'(cfg.x_extent);
      tssf_pkg::REG_YEXT:  prdata = 32'(cfg.y_extent);
      tssf_pkg::REG_XDIV:  prdata = 32'(cfg.x_divisor);
      tssf_pkg::REG_YDIV:  prdata = 32'(cfg.y_divisor);
      default:             prdata = '0;
    endcase
  end

endmodule

/* sv/tssf_datapath.sv */
module tssf_datapath #(
  parameter int QUEUE_DEPTH = 64,
  parameter int SAMPLE_BITS = 12
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  tssf_pkg::cfg_t                       cfg,
  input  logic [tssf_pkg::WORD_W-1:0]          in_word,
  input  tssf_pkg::dp_cmd_t                    cmd,
  output tssf_pkg::dp_stat_t                   stat,
  output logic [tssf_pkg::OUT_DATA_W-1:0]      out_data,
  output logic [tssf_pkg::OUT_USER_W-1:0]      out_user
);

  localparam int SB     = SAMPLE_BITS;
  localparam int P1_W   = tssf_pkg::SCALE_W + SB;
  localparam int PROD_W = P1_W + SB;
  localparam int P_W    = PROD_W - tssf_pkg::PRESS_SHIFT;
  localparam int CNT_W  = $clog2(PROD_W);
  localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int DW     = tssf_pkg::DIVR_W;
  localparam int WW     = tssf_pkg::WORD_W;

  // Captured samples.
  logic [SB-1:0] sample_x, sample_y, sample_z1, sample_z2;
  logic [SB-1:0] sample_in;

  // Multiplier and divider registers.
  logic [P1_W-1:0]   p1;
  logic [PROD_W-1:0] quo;
  logic [SB-1:0]     rem;
  logic              neg;
  logic [CNT_W-1:0]  cnt;
  logic [SB-1:0]     xq, yq;
  logic [DW-1:0]     xr, yr;

  // Event queue.
  logic [tssf_pkg::EVT_W-1:0] mem [QUEUE_DEPTH];
  logic [tssf_pkg::EVT_W-1:0] rdata;
  logic [PTR_W-1:0]           wr_ptr, rd_ptr, wr_inc, rd_inc;

  // Result registers.
  logic          r_cmd_valid, r_stored, r_dropped, r_ev_valid;
  logic [WW-1:0] r_cmd_word, r_press, r_x, r_y;

  // Combinational helpers.
  logic [SB-1:0]     diff;
  logic [SB:0]       m_trial;
  logic              m_ge;
  logic [SB-1:0]     rem_next;
  logic [DW-1:0]     dx, dy, xr_next, yr_next;
  logic [DW:0]       x_trial, y_trial;
  logic              x_ge, y_ge, lane_en;
  logic [P_W-1:0]    press, pmin_ext, pmax_ext;
  logic              accept;
  logic [WW-1:0]     ev_x, ev_y;
  logic              full_hit;

  assign sample_in = in_word[WW-1 -: SB];

  assign wr_inc = (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
  assign rd_inc = (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);

  // Magnitude of z2 - z1; the sign is kept apart.
  assign diff = (sample_z2 >= sample_z1) ? sample_z2 - sample_z1 : sample_z1 - sample_z2;

  // One restoring division step on the product, and one on each coordinate lane.
  assign m_trial  = {rem, quo[PROD_W-1]};
  assign m_ge     = m_trial >= {1'b0, sample_z1};
  assign rem_next = m_ge ? SB'(m_trial - {1'b0, sample_z1}) : m_trial[SB-1:0];

  assign dx      = (cfg.x_divisor == '0) ? DW'(1) : cfg.x_divisor;
  assign dy      = (cfg.y_divisor == '0) ? DW'(1) : cfg.y_divisor;
  assign x_trial = {xr, xq[SB-1]};
  assign y_trial = {yr, yq[SB-1]};
  assign x_ge    = x_trial >= {1'b0, dx};
  assign y_ge    = y_trial >= {1'b0, dy};
  assign xr_next = x_ge ? DW'(x_trial - {1'b0, dx}) : x_trial[DW-1:0];
  assign yr_next = y_ge ? DW'(y_trial - {1'b0, dy}) : y_trial[DW-1:0];
  assign lane_en = cnt < CNT_W'(SB);

  // Range check of the finished sample. A negative product with a zero
  // quotient truncates to zero and is not rejected for its sign.
  assign press    = quo[PROD_W-1:tssf_pkg::PRESS_SHIFT];
  assign pmin_ext = P_W'(cfg.pressure_min);
  assign pmax_ext = P_W'(cfg.pressure_max);
  assign accept   = !(neg && (quo != '0)) && (press >= pmin_ext) && (press <= pmax_ext);
  assign ev_x     = cfg.x_extent - WW'(xq);
  assign ev_y     = cfg.y_extent - WW'(yq);
  assign full_hit = wr_inc == rd_ptr;

  // Sample capture, multiply and divide.
  always_ff @(posedge clk) begin
    case (cmd.sample_sel)
      tssf_pkg::SEL_X:  sample_x  <= sample_in;
      tssf_pkg::SEL_Y:  sample_y  <= sample_in;
      tssf_pkg::SEL_Z1: sample_z1 <= sample_in;
      tssf_pkg::SEL_Z2: sample_z2 <= sample_in;
      default: begin
      end
    endcase
    if (cmd.mul1) begin
      p1 <= P1_W'(cfg.pressure_scale) * P1_W'(sample_x);
    end
    if (cmd.mul2) begin
      quo <= PROD_W'(p1) * PROD_W'(diff);
      neg <= sample_z2 < sample_z1;
      rem <= '0;
      cnt <= '0;
      xq  <= sample_x;
      yq  <= sample_y;
      xr  <= '0;
      yr  <= '0;
    end else if (cmd.div_step) begin
      quo <= {quo[PROD_W-2:0], m_ge};
      rem <= rem_next;
      cnt <= cnt + CNT_W'(1);
      if (lane_en) begin
        xq <= {xq[SB-2:0], x_ge};
        xr <= xr_next;
        yq <= {yq[SB-2:0], y_ge};
        yr <= yr_next;
      end
    end
  end

  // Queue pointers.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
    end else if (cmd.finish && accept) begin
      wr_ptr <= wr_inc;
      if (full_hit) begin
        rd_ptr <= rd_inc;
      end
    end else if (cmd.pop_read) begin
      rd_ptr <= rd_inc;
    end
  end

  // Event memory with registered read.
  always_ff @(posedge clk) begin
    if (cmd.finish && accept) begin
      mem[wr_ptr] <= {ev_y, ev_x, press[WW-1:0]};
    end
    if (cmd.pop_read) begin
      rdata <= mem[rd_ptr];
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    case (cmd.res_op)
      tssf_pkg::RES_ZERO, tssf_pkg::RES_CMD, tssf_pkg::RES_FINISH: begin
        r_cmd_valid <= cmd.res_op == tssf_pkg::RES_CMD;
        r_cmd_word  <= (cmd.res_op == tssf_pkg::RES_CMD) ? cmd.cmd_word : '0;
        r_stored    <= (cmd.res_op == tssf_pkg::RES_FINISH) && accept;
        r_dropped   <= (cmd.res_op == tssf_pkg::RES_FINISH) && accept && full_hit;
        r_ev_valid  <= 1'b0;
        r_press     <= '0;
        r_x         <= '0;
        r_y         <= '0;
      end
      tssf_pkg::RES_POP: begin
        r_cmd_valid <= 1'b0;
        r_cmd_word  <= '0;
        r_stored    <= 1'b0;
        r_dropped   <= 1'b0;
        r_ev_valid  <= 1'b1;
        r_press     <= rdata[WW-1:0];
        r_x         <= rdata[2*WW-1:WW];
        r_y         <= rdata[3*WW-1:2*WW];
      end
      default: begin
      end
    endcase
  end

  assign stat.z1_zero     = sample_z1 == '0;
  assign stat.div_last    = cnt == CNT_W'(PROD_W - 1);
  assign stat.queue_empty = rd_ptr == wr_ptr;

  assign out_data = {r_y, r_x, r_press, r_cmd_word};
  assign out_user = {stat.queue_empty, r_ev_valid, r_dropped, r_stored, r_cmd_valid};

endmodule

/* sv/tssf_ctrl.sv */
module tssf_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  tssf_pkg::opcode_t    opcode,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  input  tssf_pkg::dp_stat_t   stat,
  output tssf_pkg::dp_cmd_t    cmd
);

  tssf_pkg::state_t state, state_next;
  tssf_pkg::phase_t phase, phase_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tssf_pkg::ST_IDLE;
      phase <= tssf_pkg::PH_IDLE;
    end else begin
      state <= state_next;
      phase <= phase_next;
    end
  end

  assign s_tready = state == tssf_pkg::ST_IDLE;
  assign m_tvalid = state == tssf_pkg::ST_OUT;

  // Sequencing of one item.
  always_comb begin
    state_next = state;
    phase_next = phase;
    cmd        = '0;
    case (state)
      tssf_pkg::ST_IDLE: begin
        if (s_tvalid) begin
          state_next = tssf_pkg::ST_OUT;
          cmd.res_op = tssf_pkg::RES_ZERO;
          case (opcode)
            tssf_pkg::OP_TICK: begin
              cmd.res_op   = tssf_pkg::RES_CMD;
              cmd.cmd_word = tssf_pkg::CMD_X;
              phase_next   = tssf_pkg::PH_X;
            end
            tssf_pkg::OP_WORD: begin
              case (phase)
                tssf_pkg::PH_X: begin
                  cmd.sample_sel = tssf_pkg::SEL_X;
                  cmd.res_op     = tssf_pkg::RES_CMD;
                  cmd.cmd_word   = tssf_pkg::CMD_Y;
                  phase_next     = tssf_pkg::PH_Y;
                end
                tssf_pkg::PH_Y: begin
                  cmd.sample_sel = tssf_pkg::SEL_Y;
                  cmd.res_op     = tssf_pkg::RES_CMD;
                  cmd.cmd_word   = tssf_pkg::CMD_Z1;
                  phase_next     = tssf_pkg::PH_Z1;
                end
                tssf_pkg::PH_Z1: begin
                  cmd.sample_sel = tssf_pkg::SEL_Z1;
                  cmd.res_op     = tssf_pkg::RES_CMD;
                  cmd.cmd_word   = tssf_pkg::CMD_Z2;
                  phase_next     = tssf_pkg::PH_Z2;
                end
                tssf_pkg::PH_Z2: begin
                  // A zero z1 rejects the sample without the division.
                  cmd.sample_sel = tssf_pkg::SEL_Z2;
                  phase_next     = tssf_pkg::PH_IDLE;
                  if (!stat.z1_zero) begin
                    cmd.res_op = tssf_pkg::RES_HOLD;
                    state_next = tssf_pkg::ST_MUL1;
                  end
                end
                default: begin
                  phase_next = tssf_pkg::PH_IDLE;
                end
              endcase
            end
            tssf_pkg::OP_POP: begin
              if (!stat.queue_empty) begin
                cmd.res_op   = tssf_pkg::RES_HOLD;
                cmd.pop_read = 1'b1;
                state_next   = tssf_pkg::ST_READ;
              end
            end
            default: begin
            end
          endcase
        end
      end
      tssf_pkg::ST_MUL1: begin
        cmd.mul1   = 1'b1;
        state_next = tssf_pkg::ST_MUL2;
      end
      tssf_pkg::ST_MUL2: begin
        cmd.mul2   = 1'b1;
        state_next = tssf_pkg::ST_DIV;
      end
      tssf_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) begin
          state_next = tssf_pkg::ST_FINISH;
        end
      end
      tssf_pkg::ST_FINISH: begin
        cmd.finish = 1'b1;
        cmd.res_op = tssf_pkg::RES_FINISH;
        state_next = tssf_pkg::ST_OUT;
      end
      tssf_pkg::ST_READ: begin
        cmd.res_op = tssf_pkg::RES_POP;
        state_next = tssf_pkg::ST_OUT;
      end
      tssf_pkg::ST_OUT: begin
        if (m_tready) begin
          state_next = tssf_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = tssf_pkg::ST_IDLE;
      end
    endcase
  end

`ifndef SYNTHESIS
  // An accepted item closes the input until its result is taken.
  a_accept_blocks: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input taken again before the result was delivered");

  // A waiting result and an open input never coincide.
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    !(m_tvalid && s_tready))
    else $error("input open while a result waits");

  // The divider runs until its last step.
  a_div_runs: assert property (@(posedge clk) disable iff (rst)
    (state == tssf_pkg::ST_DIV && !stat.div_last) |=> state == tssf_pkg::ST_DIV)
    else $error("division left early");

  // The pressure check follows the last divider step.
  a_div_done: assert property (@(posedge clk) disable iff (rst)
    (state == tssf_pkg::ST_DIV && stat.div_last) |=> state == tssf_pkg::ST_FINISH)
    else $error("division did not finish");
`endif

endmodule

/* sv/touch_sample_sequencer_fifo_top.sv */
// A tick, a conversion word or a pop on an empty queue gives its result the cycle after it is
// taken; a pop with data first passes the registered queue read. A Z2 word with a nonzero z1
// runs the pressure multiply and a one-bit-per-cycle restoring divider before its result.
// One item at a time: the next item is taken the cycle after the result goes.
// Reset (rst, synchronous) idles the sequencer, empties the queue and loads the register
// defaults; the event memory itself is not cleared.
module touch_sample_sequencer_fifo_top #(
  parameter int QUEUE_DEPTH = 64,
  parameter int SAMPLE_BITS = 12
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // adc_word
  input  logic [1:0]  s_tuser,   // opcode
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,   // cmd_word, event_pressure, event_x, event_y
  output logic [4:0]  m_tuser    // cmd_valid, sample_stored, oldest_dropped, event_valid,
                                 // queue_empty
);

  tssf_pkg::cfg_t     cfg;
  tssf_pkg::dp_cmd_t  cmd;
  tssf_pkg::dp_stat_t stat;

  assign pready = 1'b1;

  tssf_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  tssf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .opcode   (tssf_pkg::opcode_t'(s_tuser)),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  tssf_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_word  (s_tdata),
    .cmd      (cmd),
    .stat     (stat),
    .out_data (m_tdata),
    .out_user (m_tuser)
  );

endmodule

/* bench/touch_sample_sequencer_fifo_top_tb.sv */
`timescale 1ns / 1ps

module touch_sample_sequencer_fifo_top_tb;

  localparam int RING_DEPTH = 64;
  localparam int IDLE_LIMIT = 4000;

  typedef struct {
    logic [15:0] pressure;
    logic [15:0] x;
    logic [15:0] y;
  } touch_event_t;

  typedef struct {
    logic        cmd_valid;
    logic [15:0] cmd_word;
    logic        stored;
    logic        dropped;
    logic        event_valid;
    logic [15:0] event_pressure;
    logic [15:0] event_x;
    logic [15:0] event_y;
    logic        queue_empty;
  } touch_result_t;

  // Scoreboard: tracks the sequencer and the event ring, and holds the results still due.
  class touch_queue_scoreboard;
    logic [11:0]  scale;
    logic [15:0]  p_min, p_max, x_ext, y_ext;
    logic [7:0]   x_div, y_div;
    tssf_pkg::phase_t phase;
    logic [11:0]  raw_x, raw_y, raw_z1;
    touch_event_t ring [RING_DEPTH];
    int unsigned  wr_ptr, rd_ptr;
    touch_result_t pending_results [$];
    int           mismatch_count;
    int           drop_count;

    function new();
      scale = tssf_pkg::RST_SCALE;
      p_min = tssf_pkg::RST_PMIN;
      p_max = tssf_pkg::RST_PMAX;
      x_ext = tssf_pkg::RST_XEXT;
      y_ext = tssf_pkg::RST_YEXT;
      x_div = tssf_pkg::RST_XDIV;
      y_div = tssf_pkg::RST_YDIV;
      phase = tssf_pkg::PH_IDLE;
      raw_x = '0;
      raw_y = '0;
      raw_z1 = '0;
      wr_ptr = 0;
      rd_ptr = 0;
      mismatch_count = 0;
      drop_count = 0;
    endfunction

    // Only the register's own width is kept.
    function void set_register(tssf_pkg::reg_idx_t idx, logic [31:0] value);
      case (idx)
        tssf_pkg::REG_SCALE: scale = value[11:0];
        tssf_pkg::REG_PMIN:  p_min = value[15:0];
        tssf_pkg::REG_PMAX:  p_max = value[15:0];
        tssf_pkg::REG_XEXT:  x_ext = value[15:0];
        tssf_pkg::REG_YEXT:  y_ext = value[15:0];
        tssf_pkg::REG_XDIV:  x_div = value[7:0];
        tssf_pkg::REG_YDIV:  y_div = value[7:0];
        default: ;
      endcase
    endfunction

    // Works out the one result that an accepted item causes.
    function void note_item(tssf_pkg::opcode_t op, logic [15:0] word);
      touch_result_t r;
      logic [11:0] sample;
      longint prod, quot;
      logic [7:0] dx, dy;
      r = '{default: '0};
      sample = word[15:4];
      case (op)
        tssf_pkg::OP_TICK: begin
          r.cmd_valid = 1'b1;
          r.cmd_word = tssf_pkg::CMD_X;
          phase = tssf_pkg::PH_X;
        end
        tssf_pkg::OP_WORD: begin
          case (phase)
            tssf_pkg::PH_X: begin
              raw_x = sample;
              r.cmd_valid = 1'b1;
              r.cmd_word = tssf_pkg::CMD_Y;
              phase = tssf_pkg::PH_Y;
            end
            tssf_pkg::PH_Y: begin
              raw_y = sample;
              r.cmd_valid = 1'b1;
              r.cmd_word = tssf_pkg::CMD_Z1;
              phase = tssf_pkg::PH_Z1;
            end
            tssf_pkg::PH_Z1: begin
              raw_z1 = sample;
              r.cmd_valid = 1'b1;
              r.cmd_word = tssf_pkg::CMD_Z2;
              phase = tssf_pkg::PH_Z2;
            end
            tssf_pkg::PH_Z2: begin
              phase = tssf_pkg::PH_IDLE;
              // Reject on zero z1, a negative quotient or a pressure out of range.
              if (raw_z1 != 0) begin
                prod = longint'(scale) * longint'(raw_x) *
                       (longint'(sample) - longint'(raw_z1));
                quot = prod / longint'(raw_z1);
                if (quot >= 0 && (quot >>> 12) >= p_min && (quot >>> 12) <= p_max) begin
                  dx = (x_div == 0) ? 8'd1 : x_div;
                  dy = (y_div == 0) ? 8'd1 : y_div;
                  ring[wr_ptr].pressure = 16'(quot >>> 12);
                  ring[wr_ptr].x = x_ext - ({4'b0, raw_x} / {8'b0, dx});
                  ring[wr_ptr].y = y_ext - ({4'b0, raw_y} / {8'b0, dy});
                  wr_ptr = (wr_ptr + 1) % RING_DEPTH;
                  r.stored = 1'b1;
                  // A full ring loses its oldest event.
                  if (wr_ptr == rd_ptr) begin
                    rd_ptr = (rd_ptr + 1) % RING_DEPTH;
                    r.dropped = 1'b1;
                    drop_count++;
                  end
                end
              end
            end
            default: phase = tssf_pkg::PH_IDLE;
          endcase
        end
        tssf_pkg::OP_POP: begin
          if (rd_ptr != wr_ptr) begin
            r.event_valid = 1'b1;
            r.event_pressure = ring[rd_ptr].pressure;
            r.event_x = ring[rd_ptr].x;
            r.event_y = ring[rd_ptr].y;
            rd_ptr = (rd_ptr + 1) % RING_DEPTH;
          end
        end
        default: ;
      endcase
      r.queue_empty = (rd_ptr == wr_ptr);
      pending_results.push_back(r);
    endfunction

    task report(string msg);
      mismatch_count++;
      if (mismatch_count <= 40) $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task compare_field(string name, logic [15:0] got, logic [15:0] want);
      if (got !== want) report($sformatf("%s: got 0x%0h, expected 0x%0h", name, got, want));
    endtask

    task compare_flag(string name, logic got, logic want);
      if (got !== want) report($sformatf("%s: got %0b, expected %0b", name, got, want));
    endtask

    task check_result(touch_result_t got);
      touch_result_t want;
      if (pending_results.size() == 0) begin
        report("result arrived with nothing expected");
        return;
      end
      want = pending_results.pop_front();
      compare_flag("cmd_valid", got.cmd_valid, want.cmd_valid);
      compare_field("cmd_word", got.cmd_word, want.cmd_word);
      compare_flag("sample_stored", got.stored, want.stored);
      compare_flag("oldest_dropped", got.dropped, want.dropped);
      compare_flag("event_valid", got.event_valid, want.event_valid);
      compare_field("event_pressure", got.event_pressure, want.event_pressure);
      compare_field("event_x", got.event_x, want.event_x);
      compare_field("event_y", got.event_y, want.event_y);
      compare_flag("queue_empty", got.queue_empty, want.queue_empty);
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst;
  logic        psel, penable, pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        s_tvalid;
  logic        s_tready;
  logic [15:0] s_tdata;   // adc_word
  logic [1:0]  s_tuser;   // opcode
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [63:0] m_tdata;   // cmd_word, event_pressure, event_x, event_y
  logic [4:0]  m_tuser;   // cmd_valid, sample_stored, oldest_dropped, event_valid,
                          // queue_empty

  touch_queue_scoreboard sb;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_request = 0;
  int hold_left = 0;
  int items_sent = 0;
  int idle_cycles = 0;

  touch_sample_sequencer_fifo_top DUT (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always #5 clk = ~clk;

  // Receiver: random stalls, plus a long hold-off when one is requested.
  always @(negedge clk) begin
    if (hold_request > 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      m_tready <= 1'b0;
      hold_left--;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Monitor and watchdog, both sampled at the rising edge.
  always @(posedge clk) begin : monitor
    touch_result_t got;
    if (!rst) begin
      if (s_tvalid && s_tready) sb.note_item(tssf_pkg::opcode_t'(s_tuser), s_tdata);
      if (m_tvalid && m_tready) begin
        got.cmd_word = m_tdata[15:0];
        got.event_pressure = m_tdata[31:16];
        got.event_x = m_tdata[47:32];
        got.event_y = m_tdata[63:48];
        got.cmd_valid = m_tuser[0];
        got.stored = m_tuser[1];
        got.dropped = m_tuser[2];
        got.event_valid = m_tuser[3];
        got.queue_empty = m_tuser[4];
        sb.check_result(got);
      end
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("watchdog: no item moved for %0d cycles", IDLE_LIMIT);
        $display("** touch_sample_sequencer_fifo_top: FAILED **");
        $finish;
      end
    end
  end

  // Offers one item, with random idle cycles ahead of it, and waits until it is taken.
  task automatic send_item(tssf_pkg::opcode_t op, logic [15:0] word);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tdata <= word;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
    items_sent++;
  endtask

  // One full sequence: tick, then the X, Y, Z1 and Z2 conversion words.
  task automatic send_sample(logic [11:0] sx, logic [11:0] sy, logic [11:0] sz1,
                             logic [11:0] sz2);
    send_item(tssf_pkg::OP_TICK, 16'($urandom));
    send_item(tssf_pkg::OP_WORD, {sx, 4'($urandom)});
    send_item(tssf_pkg::OP_WORD, {sy, 4'($urandom)});
    send_item(tssf_pkg::OP_WORD, {sz1, 4'($urandom)});
    send_item(tssf_pkg::OP_WORD, {sz2, 4'($urandom)});
  endtask

  // Random sample content; mostly z2 a little above z1 so that pressures stay plausible.
  task automatic send_random_sample(bit well_sized);
    int z1, z2, span;
    if (well_sized || $urandom_range(19) != 0) z1 = $urandom_range(4095, 1);
    else z1 = 0;
    span = (z1 < 4095 - z1) ? z1 : 4095 - z1;
    if (well_sized) begin
      z2 = z1 + $urandom_range(span);
    end else begin
      case ($urandom_range(9))
        0, 1, 2, 3, 4, 5: z2 = z1 + $urandom_range(span);
        6, 7: z2 = $urandom_range(4095);
        8: z2 = z1;
        default: z2 = $urandom_range(z1);
      endcase
    end
    send_sample(12'($urandom), 12'($urandom), 12'(z1), 12'(z2));
  endtask

  // Mostly well-formed sequences; the rest pops, noise and cut-off sequences.
  task automatic send_random_unit(int pop_pct);
    int pick;
    pick = $urandom_range(99);
    if (pick < pop_pct) begin
      send_item(tssf_pkg::OP_POP, 16'($urandom));
    end else if (pick < pop_pct + 5) begin
      send_item(tssf_pkg::opcode_t'($urandom_range(3)), 16'($urandom));
    end else if (pick < pop_pct + 10) begin
      send_item(tssf_pkg::OP_TICK, 16'($urandom));
      repeat ($urandom_range(3)) send_item(tssf_pkg::OP_WORD, 16'($urandom));
    end else begin
      send_random_sample(1'b0);
    end
  endtask

  // Sender stops until every expected result has come back.
  task automatic wait_for_results();
    s_tvalid <= 1'b0;
    do @(negedge clk); while (sb.pending_results.size() != 0);
  endtask

  task automatic apb_write(tssf_pkg::reg_idx_t idx, logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.set_register(idx, value);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk);
  endtask

  // Registers change only once the block has gone quiet.
  task automatic reconfigure(logic [31:0] v_scale, logic [31:0] v_min, logic [31:0] v_max,
                             logic [31:0] v_xext, logic [31:0] v_yext,
                             logic [31:0] v_xdiv, logic [31:0] v_ydiv);
    wait_for_results();
    repeat (45) @(negedge clk);
    apb_write(tssf_pkg::REG_SCALE, v_scale);
    apb_write(tssf_pkg::REG_PMIN, v_min);
    apb_write(tssf_pkg::REG_PMAX, v_max);
    apb_write(tssf_pkg::REG_XEXT, v_xext);
    apb_write(tssf_pkg::REG_YEXT, v_yext);
    apb_write(tssf_pkg::REG_XDIV, v_xdiv);
    apb_write(tssf_pkg::REG_YDIV, v_ydiv);
  endtask

  initial begin : stimulus
    int target;
    sb = new();
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = tssf_pkg::OP_NOP;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: empty pop, no-op, word while idle, restart mid-sequence, stored sample and pop, rejections.
    send_item(tssf_pkg::OP_POP, 16'hffff);
    send_item(tssf_pkg::OP_NOP, 16'hffff);
    send_item(tssf_pkg::OP_WORD, 16'hffff);
    send_item(tssf_pkg::OP_TICK, 16'h0000);
    send_item(tssf_pkg::OP_WORD, {12'd1234, 4'hf});
    send_sample(12'd2000, 12'hfff, 12'd500, 12'd1500);
    send_item(tssf_pkg::OP_POP, 16'h0000);
    send_sample(12'hfff, 12'd0, 12'd0, 12'hfff);
    send_sample(12'd1000, 12'd100, 12'd3000, 12'd100);
    send_sample(12'hfff, 12'hfff, 12'd1, 12'hfff);
    send_item(tssf_pkg::OP_POP, 16'h0000);

    // Reset settings, no idling on either side.
    while (items_sent < 80) send_random_unit(15);

    // Wide acceptance and no pops until the ring overflows; the receiver first holds off.
    reconfigure(32'd4095, 32'd0, 32'd65535, 32'd0, 32'd65535, 32'd0, 32'd255);
    hold_request = 400;
    while (sb.drop_count < 3 && items_sent < 1500) send_random_sample(1'b1);
    repeat (66) send_item(tssf_pkg::OP_POP, 16'($urandom));

    // Zero scale and zero range, with sender gaps.
    send_idle_pct = 68;
    reconfigure(32'd0, 32'd0, 32'd0, 32'd65535, 32'd0, 32'd1, 32'd1);
    target = items_sent + 30;
    while (items_sent < target) send_random_unit(20);

    // Random settings with junk above each register's width, with receiver stalls.
    send_idle_pct = 0;
    recv_stall_pct = 68;
    reconfigure($urandom, {16'($urandom), 16'($urandom_range(150))},
                {16'($urandom), 16'($urandom_range(65535, 2000))},
                $urandom, $urandom, $urandom, $urandom);
    target = items_sent + 25;
    while (items_sent < target) send_random_unit(20);
    wait_for_results();
    target = items_sent + 25;
    while (items_sent < target) send_random_unit(20);

    // Both sides idling.
    send_idle_pct = 31;
    recv_stall_pct = 31;
    reconfigure(32'd2048, 32'd300, 32'd20000, 32'd800, 32'd480, 32'd3, 32'd255);
    target = items_sent + 30;
    while (items_sent < target) send_random_unit(20);

    wait_for_results();
    repeat (60) @(posedge clk);
    if (sb.pending_results.size() != 0) sb.report("results still expected at the end");
    if (sb.mismatch_count == 0) begin
      $display("** touch_sample_sequencer_fifo_top: PASSED **");
    end else begin
      $display("** touch_sample_sequencer_fifo_top: FAILED **");
    end
    $finish;
  end

endmodule
